>>> hw/rtl/cnf3_clause_parser_macros.svh
// Assertion macros shared by the clause parser RTL.
// Assertions are clocked on clk_i and disabled while rst_ni is low.
`ifndef CNF3_CLAUSE_PARSER_MACROS_SVH
`define CNF3_CLAUSE_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
`define CNF3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("clause parser assertion failed");
`define CNF3_ASSERT_IMP(lbl, ante, cons) \
  `CNF3_ASSERT(lbl, (ante) |-> (cons))
`define CNF3_ASSERT_NEXT(lbl, ante, cons) \
  `CNF3_ASSERT(lbl, (ante) |=> (cons))
`else
`define CNF3_ASSERT(lbl, prop)
`define CNF3_ASSERT_IMP(lbl, ante, cons)
`define CNF3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/cnf3_pkg.sv
// Types and constants of the 3-CNF clause parser.
// Used by cnf3_step and cnf3_clause_parser; depends on nothing.
package cnf3_pkg;

  typedef enum logic [14:0] {
    POS_START  = 15'h0001,
    POS_VAR0   = 15'h0002,
    POS_VAR1   = 15'h0004,
    POS_VAR2   = 15'h0008,
    POS_NEGB0  = 15'h0010,
    POS_NEGB1  = 15'h0020,
    POS_NEGB2  = 15'h0040,
    POS_LET0   = 15'h0080,
    POS_LET1   = 15'h0100,
    POS_LET2   = 15'h0200,
    POS_SEP0   = 15'h0400,
    POS_SEP1   = 15'h0800,
    POS_CLOSE  = 15'h1000,
    POS_AFTER  = 15'h2000,
    POS_REOPEN = 15'h4000
  } pos_e;

  localparam logic [7:0] NEG_FIRST  = 8'hC2;
  localparam logic [7:0] NEG_SECOND = 8'hAC;
  localparam logic [7:0] CH_SEP     = 8'h76;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_AND     = 8'h5E;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam logic [1:0] KIND_CLAUSE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_VARIABLE  = 3'd1;
  localparam logic [2:0] ERR_SEP       = 3'd2;
  localparam logic [2:0] ERR_CLOSE     = 3'd3;
  localparam logic [2:0] ERR_OPEN      = 3'd4;
  localparam logic [2:0] ERR_TRAILING  = 3'd5;

  typedef struct packed {
    pos_e       pos;
    logic       neg_pend;
    logic [7:0] let0;
    logic [7:0] let1;
    logic       neg0;
    logic       neg1;
    logic       drain;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [2:0] err;
    logic [7:0] let0;
    logic       neg0;
    logic [7:0] let1;
    logic       neg1;
    logic [7:0] let2;
    logic       neg2;
  } result_t;

  localparam parse_state_t PARSE_RESET = '{
    pos: POS_START, neg_pend: 1'b0, let0: 8'h00, let1: 8'h00,
    neg0: 1'b0, neg1: 1'b0, drain: 1'b0
  };

endpackage

>>> hw/rtl/cnf3_step.sv
// Next-state and result logic for one text byte of the clause parser.
// Purely combinational; uses types and constants from cnf3_pkg.
module cnf3_step import cnf3_pkg::*; (
  input  parse_state_t cur_i,
  input  logic [7:0]   byte_i,
  output parse_state_t nxt_o,
  output result_t      res_o
);

  logic       is_ws;
  logic       is_letter;
  logic       fail;
  logic [2:0] fail_code;
  logic       take;
  logic [1:0] idx;
  pos_e       let_pos;

  assign is_ws = (byte_i == 8'h20) || (byte_i >= 8'h09 && byte_i <= 8'h0D);
  assign is_letter = (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                     (byte_i >= 8'h61 && byte_i <= 8'h7A);

  // literal slot of the current position
  always_comb begin
    idx     = 2'd0;
    let_pos = POS_LET0;
    if (cur_i.pos == POS_VAR1 || cur_i.pos == POS_NEGB1 || cur_i.pos == POS_LET1) begin
      idx     = 2'd1;
      let_pos = POS_LET1;
    end else if (cur_i.pos == POS_VAR2 || cur_i.pos == POS_NEGB2 ||
                 cur_i.pos == POS_LET2) begin
      idx     = 2'd2;
      let_pos = POS_LET2;
    end
  end

  always_comb begin
    nxt_o     = cur_i;
    res_o     = '0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    take      = 1'b0;

    if (cur_i.drain) begin
      if (byte_i == CH_NUL) begin
        nxt_o = PARSE_RESET;
      end
    end else begin
      case (cur_i.pos)
        POS_NEGB0, POS_NEGB1, POS_NEGB2: begin
          if (byte_i == NEG_SECOND) begin
            nxt_o.neg_pend = 1'b1;
            nxt_o.pos      = let_pos;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_VARIABLE;
          end
        end
        POS_VAR0, POS_VAR1, POS_VAR2: begin
          if (is_ws) begin
          end else if (byte_i == NEG_FIRST) begin
            case (idx)
              2'd0:    nxt_o.pos = POS_NEGB0;
              2'd1:    nxt_o.pos = POS_NEGB1;
              default: nxt_o.pos = POS_NEGB2;
            endcase
          end else if (is_letter) begin
            take = 1'b1;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_VARIABLE;
          end
        end
        POS_LET0, POS_LET1, POS_LET2: begin
          if (is_ws) begin
          end else if (is_letter) begin
            take = 1'b1;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_VARIABLE;
          end
        end
        POS_SEP0, POS_SEP1: begin
          if (is_ws) begin
          end else if (byte_i == CH_SEP) begin
            nxt_o.pos = (cur_i.pos == POS_SEP0) ? POS_VAR1 : POS_VAR2;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_SEP;
          end
        end
        POS_CLOSE: begin
          if (is_ws) begin
          end else if (byte_i == CH_CLOSE) begin
            nxt_o.pos = POS_AFTER;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_CLOSE;
          end
        end
        POS_AFTER: begin
          if (is_ws) begin
          end else if (byte_i == CH_AND) begin
            nxt_o.pos = POS_REOPEN;
          end else if (byte_i == CH_NUL) begin
            res_o.valid = 1'b1;
            res_o.kind  = KIND_ACCEPT;
            nxt_o       = PARSE_RESET;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_TRAILING;
          end
        end
        POS_REOPEN: begin
          if (is_ws) begin
          end else if (byte_i == CH_OPEN) begin
            nxt_o.pos = POS_VAR0;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_OPEN;
          end
        end
        default: begin
          // start of text: no whitespace allowed before the first clause
          if (byte_i == CH_OPEN) begin
            nxt_o.pos = POS_VAR0;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_OPEN;
          end
        end
      endcase

      if (take) begin
        nxt_o.neg_pend = 1'b0;
        case (idx)
          2'd0: begin
            nxt_o.let0 = byte_i;
            nxt_o.neg0 = cur_i.neg_pend;
            nxt_o.pos  = POS_SEP0;
          end
          2'd1: begin
            nxt_o.let1 = byte_i;
            nxt_o.neg1 = cur_i.neg_pend;
            nxt_o.pos  = POS_SEP1;
          end
          default: begin
            // third letter: emit the clause before the closing bracket is seen
            res_o.valid = 1'b1;
            res_o.kind  = KIND_CLAUSE;
            res_o.let0  = cur_i.let0;
            res_o.neg0  = cur_i.neg0;
            res_o.let1  = cur_i.let1;
            res_o.neg1  = cur_i.neg1;
            res_o.let2  = byte_i;
            res_o.neg2  = cur_i.neg_pend;
            nxt_o.pos   = POS_CLOSE;
          end
        endcase
      end

      if (fail) begin
        res_o.valid = 1'b1;
        res_o.kind  = KIND_ERROR;
        res_o.err   = fail_code;
        if (byte_i == CH_NUL) begin
          nxt_o = PARSE_RESET;
        end else begin
          nxt_o.drain = 1'b1;
        end
      end
    end
  end

endmodule

>>> hw/rtl/cnf3_clause_parser.sv
// Top level of the 3-CNF clause parser: input register, step logic, result register.
// Depends on cnf3_pkg, cnf3_step and cnf3_clause_parser_macros.svh.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, text_byte_i) takes one byte of
//   formula text per item; a zero byte ends the text. The output channel
//   (out_valid_o, out_stall_i and the result fields) gives at most one result
//   per byte: a clause when its third letter arrives, an accept on the
//   terminator, or one error per text, after which bytes are dropped up to
//   the terminator.
//   A byte taken is held in the input register and parsed from there; its
//   result, if any, is registered in the result register and valid from then on.
//   Throughput: one byte per cycle while the receiver does not stall; the parser
//   state is a single one-hot position register plus two held literals and flags.
//   When the receiver stalls, a held result stays put and the byte in the
//   input register waits, whether or not it gives a result; in_stall_o is
//   high while that register is occupied and the held result is stalled.
//   Items stay in order and none is dropped.
//   Reset (rst_ni low, asynchronous) empties both registers and returns the
//   parser to the start of a text.
`include "cnf3_clause_parser_macros.svh"

module cnf3_clause_parser import cnf3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [2:0] error_code_o,
  output logic [7:0] first_letter_o,
  output logic       first_negated_o,
  output logic [7:0] second_letter_o,
  output logic       second_negated_o,
  output logic [7:0] third_letter_o,
  output logic       third_negated_o
);

  logic         stage_valid_q, stage_valid_d;
  logic [7:0]   byte_q;
  parse_state_t state_q;
  parse_state_t state_nxt;
  result_t      res;
  result_t      out_q;
  logic         out_valid_q, out_valid_d;
  logic         proc;
  logic         load;

  cnf3_step u_step (
    .cur_i  (state_q),
    .byte_i (byte_q),
    .nxt_o  (state_nxt),
    .res_o  (res)
  );

  // process the held byte when the result register is free or draining
  assign proc       = stage_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = stage_valid_q && !proc;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (load) begin
      stage_valid_d = 1'b1;
    end else if (proc) begin
      stage_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc && res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= PARSE_RESET;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
      if (proc) begin
        state_q <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= text_byte_i;
    end
    if (proc && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign error_code_o     = out_q.err;
  assign first_letter_o   = out_q.let0;
  assign first_negated_o  = out_q.neg0;
  assign second_letter_o  = out_q.let1;
  assign second_negated_o = out_q.neg1;
  assign third_letter_o   = out_q.let2;
  assign third_negated_o  = out_q.neg2;

  `CNF3_ASSERT_IMP(a_clause_no_err, out_valid_o && kind_o == KIND_CLAUSE,
                   error_code_o == ERR_NONE)
  `CNF3_ASSERT_IMP(a_other_no_lits, out_valid_o && kind_o != KIND_CLAUSE,
                   first_letter_o == 8'h00 && second_letter_o == 8'h00 &&
                   third_letter_o == 8'h00 && !first_negated_o &&
                   !second_negated_o && !third_negated_o)
  `CNF3_ASSERT_NEXT(a_error_drains,
                    proc && res.valid && res.kind == KIND_ERROR && byte_q != CH_NUL,
                    state_q.drain)
  `CNF3_ASSERT_IMP(a_empty_no_stall, !stage_valid_q, !in_stall_o)
  `CNF3_ASSERT_NEXT(a_load_fills, load, stage_valid_q)
  `CNF3_ASSERT_IMP(a_out_reg_valid, out_valid_o, out_q.valid)

endmodule
